[sv/sact_pkg.sv]
// Package: shared types and constants of the set-associative cache tag store.
package sact_pkg;

    localparam int unsigned SETS      = 1024;
    localparam int unsigned WAYS      = 16;
    localparam int unsigned SET_BITS  = $clog2(SETS);
    localparam int unsigned WAY_BITS  = $clog2(WAYS);
    localparam int unsigned LINES     = SETS * WAYS;
    localparam int unsigned LINE_BITS = SET_BITS + WAY_BITS;

    // Tag (32) + stamp (32) + owner + dirty + valid
    localparam int unsigned ENTRY_BITS = 67;

    localparam logic [15:0] LFSR_SEED = 16'hACE1;

    localparam logic [1:0] MODE_LRU    = 2'd0;
    localparam logic [1:0] MODE_RANDOM = 2'd1;
    localparam logic [1:0] MODE_PART   = 2'd2;

    localparam logic [1:0] REG_MODE  = 2'd0;
    localparam logic [1:0] REG_WAYS  = 2'd1;
    localparam logic [1:0] REG_CORE0 = 2'd2;

    localparam logic CMD_LOOKUP  = 1'b0;
    localparam logic CMD_INSTALL = 1'b1;

    typedef struct packed {
        logic        command;
        logic [31:0] line_address;
        logic        write_req;
        logic        core_id;
        logic [31:0] timestamp;
    } t_in_word;

    typedef struct packed {
        logic        hit;
        logic [3:0]  victim_way;
        logic        evicted_valid;
        logic [31:0] evicted_address;
        logic        evicted_dirty;
        logic        evicted_core;
        logic [31:0] read_accesses;
        logic [31:0] write_accesses;
        logic [31:0] read_misses;
        logic [31:0] write_misses;
        logic [31:0] dirty_evictions;
    } t_out_word;

    typedef struct packed {
        logic [31:0] tag;
        logic [31:0] stamp;
        logic        owner;
        logic        dirty;
        logic        valid;
    } t_entry;

endpackage

[sv/sact_ram.sv]
// Generic single-port-write, single-port-read RAM with registered read data.
module sact_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[sv/set_assoc_cache_tag_store.sv]
// Top level: tag store of a two-core set-associative cache with LRU/random/partitioned replacement.
//
// One item at a time. An item reads its set one way per cycle from a single line RAM
// (16384 x 67 bits, registered read), so the shared scan unit (one tag compare, one stamp
// compare, one valid test) walks the active ways; then S_PICK picks the victim, S_WRITE
// writes the hit or chosen way back and S_OUT presents the result word. An install in
// random mode first runs the LFSR remainder one bit per cycle in S_MOD. The next input
// word is taken the cycle after the result word has been handed off. After reset the
// block first clears the line RAM, one line per cycle, and accepts no input word
// meanwhile; configuration writes are taken at any time but belong between items.
module set_assoc_cache_tag_store
    import sact_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  t_in_word    i_data,
    output logic        o_valid,
    input  logic        i_ready,
    output t_out_word   o_data,
    input  logic        i_cfg_we,
    input  logic [1:0]  i_cfg_index,
    input  logic [4:0]  i_cfg_data
);

    typedef enum logic [2:0] {
        S_CLEAR, S_IDLE, S_MOD, S_SCAN, S_PICK, S_WRITE, S_OUT
    } t_state;

    t_state r_state;

    logic [1:0]  r_mode;
    logic [4:0]  r_ways;
    logic [3:0]  r_core0;
    logic [15:0] r_lfsr;

    logic [31:0] r_cnt_rd, r_cnt_wr, r_cnt_rm, r_cnt_wm, r_cnt_de;

    t_in_word    r_req;
    t_out_word   r_out;
    logic        r_out_valid;

    logic [LINE_BITS-1:0] r_clr;
    logic [WAY_BITS:0]    r_rd_way;   // next way address issued
    logic [WAY_BITS:0]    r_cmp_way;  // way whose data is now on the read bus
    logic                 r_rd_live;

    logic                 r_found;    // hit (lookup) or free way (install)
    logic [WAY_BITS-1:0]  r_fway;
    logic                 r_best_ok;
    logic [WAY_BITS-1:0]  r_best;
    logic [31:0]          r_best_stamp;
    t_entry               r_best_e;
    t_entry               r_hit_e;
    t_entry               r_vict_e;   // entry of the chosen victim

    logic [3:0]           r_bit;      // index of the LFSR bit fed to the remainder step
    logic [WAY_BITS:0]    r_rem;      // partial remainder of the next LFSR value

    // RAM
    logic                 ram_we;
    logic [LINE_BITS-1:0] ram_waddr, ram_raddr;
    t_entry               ram_wdata, ram_rdata;

    logic [SET_BITS-1:0]  set_idx;
    assign set_idx = r_req.line_address[SET_BITS-1:0];

    sact_ram #(.WIDTH(ENTRY_BITS), .DEPTH(LINES)) u_lines (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Active way count clamped to 1..WAYS
    logic [WAY_BITS:0] nw;
    always_comb begin
        if (r_ways == 5'd0) begin
            nw = (WAY_BITS+1)'(1);
        end else if (r_ways > 5'(WAYS)) begin
            nw = (WAY_BITS+1)'(WAYS);
        end else begin
            nw = (WAY_BITS+1)'(r_ways);
        end
    end

    // Partition bounds for the scan window
    logic [WAY_BITS:0] split, lo, hi;
    logic              use_part;
    always_comb begin
        split = ({1'b0, r_core0} < nw) ? (WAY_BITS+1)'(r_core0) : nw;
        lo    = r_req.core_id ? split : '0;
        hi    = r_req.core_id ? nw : split;
        use_part = (r_mode == MODE_PART) && (lo < hi);
    end

    // LFSR next value and random victim modulo nw (one restoring step per cycle)
    logic        lfsr_bit;
    logic [15:0] lfsr_next;
    assign lfsr_bit  = r_lfsr[0] ^ r_lfsr[2] ^ r_lfsr[3] ^ r_lfsr[5];
    assign lfsr_next = {lfsr_bit, r_lfsr[15:1]};

    logic [WAY_BITS:0] rem_sh, rem_next;
    assign rem_sh   = {r_rem[WAY_BITS-1:0], lfsr_next[r_bit]};
    assign rem_next = (rem_sh >= nw) ? rem_sh - nw : rem_sh;

    logic [WAY_BITS:0] rnd_way;
    assign rnd_way = r_rem;

    // Scan data: compare the way on the read bus
    logic in_win, tag_hit, stamp_lt;
    logic [WAY_BITS-1:0] cway;
    assign cway     = r_cmp_way[WAY_BITS-1:0];
    assign in_win   = use_part ? (r_cmp_way >= lo && r_cmp_way < hi) : 1'b1;
    assign tag_hit  = ram_rdata.valid && (ram_rdata.owner == r_req.core_id)
                      && (ram_rdata.tag == r_req.line_address);
    assign stamp_lt = !r_best_ok || (ram_rdata.stamp < r_best_stamp);

    always_comb begin
        ram_raddr = {set_idx, r_rd_way[WAY_BITS-1:0]};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_mode      <= MODE_LRU;
            r_ways      <= 5'd16;
            r_core0     <= 4'd8;
            r_lfsr      <= LFSR_SEED;
            r_cnt_rd    <= '0;
            r_cnt_wr    <= '0;
            r_cnt_rm    <= '0;
            r_cnt_wm    <= '0;
            r_cnt_de    <= '0;
            r_out_valid <= 1'b0;
            r_rd_live   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_MODE:  r_mode  <= i_cfg_data[1:0];
                    REG_WAYS:  r_ways  <= i_cfg_data;
                    REG_CORE0: r_core0 <= i_cfg_data[3:0];
                    default: ;
                endcase
            end
            if (r_out_valid && i_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (&r_clr) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (i_valid && o_ready) begin
                        r_req     <= i_data;
                        r_rd_way  <= '0;
                        r_rd_live <= 1'b0;
                        r_found   <= 1'b0;
                        r_best_ok <= 1'b0;
                        r_rem     <= '0;
                        r_bit     <= 4'd15;
                        // Random installs need the victim way before the scan
                        if (i_data.command == CMD_INSTALL && r_mode == MODE_RANDOM) begin
                            r_state <= S_MOD;
                        end else begin
                            r_state <= S_SCAN;
                        end
                    end
                end
                S_MOD: begin
                    r_rem <= rem_next;
                    r_bit <= r_bit - 1'b1;
                    if (r_bit == 4'd0) begin
                        r_state <= S_SCAN;
                    end
                end
                S_SCAN: begin
                    // Issue next read while ways remain
                    if (r_rd_way < nw) begin
                        r_rd_way <= r_rd_way + 1'b1;
                    end
                    r_cmp_way <= r_rd_way;
                    r_rd_live <= r_rd_way < nw;
                    if (r_rd_live) begin
                        if (r_req.command == CMD_LOOKUP) begin
                            if (!r_found && tag_hit) begin
                                r_found <= 1'b1;
                                r_fway  <= cway;
                                r_hit_e <= ram_rdata;
                            end
                        end else if (!r_found && !ram_rdata.valid) begin
                            r_found <= 1'b1;
                            r_fway  <= cway;
                        end
                        if (in_win && stamp_lt) begin
                            r_best_ok    <= 1'b1;
                            r_best       <= cway;
                            r_best_stamp <= ram_rdata.stamp;
                        end
                        if (cway == rnd_way[WAY_BITS-1:0] && r_mode == MODE_RANDOM) begin
                            r_vict_e <= ram_rdata;
                        end else if (r_mode != MODE_RANDOM && in_win && stamp_lt) begin
                            r_vict_e <= ram_rdata;
                        end
                    end else if (r_rd_way >= nw && r_cmp_way == r_rd_way) begin
                        r_state <= S_PICK;
                    end
                end
                S_PICK: begin
                    if (r_req.command == CMD_INSTALL && !r_found) begin
                        if (r_mode == MODE_RANDOM) begin
                            r_lfsr <= lfsr_next;
                            r_best <= rnd_way[WAY_BITS-1:0];
                        end
                    end
                    r_state <= S_WRITE;
                end
                S_WRITE: begin
                    r_out.hit             <= 1'b0;
                    r_out.victim_way      <= '0;
                    r_out.evicted_valid   <= 1'b0;
                    r_out.evicted_address <= '0;
                    r_out.evicted_dirty   <= 1'b0;
                    r_out.evicted_core    <= 1'b0;
                    if (r_req.command == CMD_LOOKUP) begin
                        r_out.hit <= r_found;
                        if (r_req.write_req) begin
                            r_cnt_wr <= r_cnt_wr + 1'b1;
                            if (!r_found) r_cnt_wm <= r_cnt_wm + 1'b1;
                        end else begin
                            r_cnt_rd <= r_cnt_rd + 1'b1;
                            if (!r_found) r_cnt_rm <= r_cnt_rm + 1'b1;
                        end
                    end else if (r_found) begin
                        r_out.victim_way <= 4'(r_fway);
                    end else begin
                        r_out.victim_way      <= 4'(r_best);
                        r_out.evicted_valid   <= 1'b1;
                        r_out.evicted_address <= r_vict_e.tag;
                        r_out.evicted_dirty   <= r_vict_e.dirty;
                        r_out.evicted_core    <= r_vict_e.owner;
                        if (r_vict_e.dirty) r_cnt_de <= r_cnt_de + 1'b1;
                    end
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    // Output register is always empty here: the previous word was taken before this item was accepted
                    r_out.read_accesses   <= r_cnt_rd;
                    r_out.write_accesses  <= r_cnt_wr;
                    r_out.read_misses     <= r_cnt_rm;
                    r_out.write_misses    <= r_cnt_wm;
                    r_out.dirty_evictions <= r_cnt_de;
                    r_out_valid           <= 1'b1;
                    r_state               <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Write port: clear sweep, then at most one write per item
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_clr;
        ram_wdata = '0;
        if (r_state == S_CLEAR) begin
            ram_we = 1'b1;
        end else if (r_state == S_WRITE) begin
            if (r_req.command == CMD_LOOKUP) begin
                ram_we          = r_found;
                ram_waddr       = {set_idx, r_fway};
                ram_wdata       = r_hit_e;
                ram_wdata.stamp = r_req.timestamp;
                ram_wdata.dirty = r_hit_e.dirty | r_req.write_req;
            end else begin
                ram_we          = 1'b1;
                ram_waddr       = {set_idx, r_found ? r_fway : r_best};
                ram_wdata.tag   = r_req.line_address;
                ram_wdata.stamp = r_req.timestamp;
                ram_wdata.owner = r_req.core_id;
                ram_wdata.dirty = r_req.write_req;
                ram_wdata.valid = 1'b1;
            end
        end
    end

    assign o_ready = (r_state == S_IDLE) && !r_out_valid;
    assign o_valid = r_out_valid;
    assign o_data  = r_out;

endmodule

[tb/set_assoc_cache_tag_store_tb.sv]
// Testbench for the two-core set-associative cache tag store: lookups, installs, replacement.
`timescale 1ns / 100ps

module set_assoc_cache_tag_store_tb;
    import sact_pkg::*;

    logic        i_clk = 1'b0;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    t_in_word    i_data;
    logic        o_valid;
    logic        i_ready;
    t_out_word   o_data;
    logic        i_cfg_we;
    logic [1:0]  i_cfg_index;
    logic [4:0]  i_cfg_data;

    set_assoc_cache_tag_store DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_data      (i_data),
        .o_valid     (o_valid),
        .i_ready     (i_ready),
        .o_data      (o_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    // 10 ns clock
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Shadow of the tag store, the LFSR, the counters and the registers
    logic        shadow_valid [LINES];
    logic        shadow_dirty [LINES];
    logic        shadow_owner [LINES];
    logic [31:0] shadow_tag   [LINES];
    logic [31:0] shadow_stamp [LINES];
    logic [15:0] shadow_lfsr;
    logic [31:0] cnt_rd, cnt_wr, cnt_rd_miss, cnt_wr_miss, cnt_dirty_ev;
    logic [1:0]  cfg_mode;
    logic [4:0]  cfg_ways;
    logic [3:0]  cfg_core0;

    t_out_word   expected_words[$];
    int          error_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic [31:0] stamp_clock = 0;
    logic [9:0]  hot_sets[4];

    // Oldest way in [lo, hi); the lowest way wins on equal stamps.
    function automatic int oldest_way(int base, int lo, int hi);
        int best;
        best = lo;
        for (int i = lo; i < hi; i++)
            if (shadow_stamp[base + i] < shadow_stamp[base + best]) best = i;
        return best;
    endfunction

    // Apply one accepted word to the shadow store and return the result word it must produce.
    function automatic t_out_word predict_tag_access(t_in_word w);
        t_out_word   r;
        int          nw, base, way, split, lo, hi, k;
        bit          found;
        logic        fb;
        r = '0;
        nw = (cfg_ways == 0) ? 1 : ((cfg_ways > WAYS) ? WAYS : int'(cfg_ways));
        base = int'(w.line_address[SET_BITS-1:0]) * WAYS;
        way = 0;
        if (w.command == CMD_LOOKUP) begin
            if (w.write_req) cnt_wr++;
            else cnt_rd++;
            for (int i = 0; i < nw; i++) begin
                k = base + i;
                if (shadow_valid[k] && shadow_owner[k] == w.core_id &&
                    shadow_tag[k] == w.line_address) begin
                    r.hit = 1'b1;
                    shadow_stamp[k] = w.timestamp;
                    if (w.write_req) shadow_dirty[k] = 1'b1;
                    break;
                end
            end
            if (!r.hit) begin
                if (w.write_req) cnt_wr_miss++;
                else cnt_rd_miss++;
            end
        end else begin
            found = 1'b0;
            for (int i = 0; i < nw; i++)
                if (!shadow_valid[base + i]) begin
                    way = i;
                    found = 1'b1;
                    break;
                end
            if (!found) begin
                if (cfg_mode == MODE_RANDOM) begin
                    fb = shadow_lfsr[0] ^ shadow_lfsr[2] ^ shadow_lfsr[3] ^ shadow_lfsr[5];
                    shadow_lfsr = {fb, shadow_lfsr[15:1]};
                    way = int'(shadow_lfsr) % nw;
                end else begin
                    lo = 0;
                    hi = nw;
                    if (cfg_mode == MODE_PART) begin
                        split = (cfg_core0 < nw) ? int'(cfg_core0) : nw;
                        lo = w.core_id ? split : 0;
                        hi = w.core_id ? nw : split;
                        // empty partition: fall back to the whole set
                        if (lo >= hi) begin
                            lo = 0;
                            hi = nw;
                        end
                    end
                    way = oldest_way(base, lo, hi);
                end
                k = base + way;
                r.evicted_valid   = 1'b1;
                r.evicted_address = shadow_tag[k];
                r.evicted_dirty   = shadow_dirty[k];
                r.evicted_core    = shadow_owner[k];
                if (shadow_dirty[k]) cnt_dirty_ev++;
            end
            k = base + way;
            shadow_valid[k] = 1'b1;
            shadow_dirty[k] = w.write_req;
            shadow_owner[k] = w.core_id;
            shadow_tag[k]   = w.line_address;
            shadow_stamp[k] = w.timestamp;
            r.victim_way = way[3:0];
        end
        r.read_accesses   = cnt_rd;
        r.write_accesses  = cnt_wr;
        r.read_misses     = cnt_rd_miss;
        r.write_misses    = cnt_wr_miss;
        r.dirty_evictions = cnt_dirty_ev;
        return r;
    endfunction

    // Send one word: optional idle gap, hold valid until accepted, predict on acceptance.
    task automatic send_word(t_in_word w);
        while ($urandom_range(99) < send_idle_pct) @(negedge i_clk);
        i_data  = w;
        i_valid = 1'b1;
        do @(posedge i_clk); while (!o_ready);
        expected_words.push_back(predict_tag_access(w));
        @(negedge i_clk);
        i_valid = 1'b0;
    endtask

    task automatic wait_drained();
        while (expected_words.size() != 0) @(posedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // Write one register; only ever called while nothing is in flight.
    task automatic write_reg(logic [1:0] idx, logic [4:0] value);
        i_cfg_we    = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = value;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        case (idx)
            REG_MODE:  cfg_mode  = value[1:0];
            REG_WAYS:  cfg_ways  = value;
            REG_CORE0: cfg_core0 = value[3:0];
            default: ;
        endcase
    endtask

    task automatic set_config(logic [4:0] mode, logic [4:0] ways, logic [4:0] core0);
        wait_drained();
        write_reg(REG_MODE, mode);
        write_reg(REG_WAYS, ways);
        write_reg(REG_CORE0, core0);
    endtask

    function automatic t_in_word make_word(logic cmd, logic [31:0] addr, logic wr,
                                          logic core, logic [31:0] stamp);
        t_in_word w;
        w.command      = cmd;
        w.line_address = addr;
        w.write_req    = wr;
        w.core_id      = core;
        w.timestamp    = stamp;
        return w;
    endfunction

    // Mostly a few hot sets with a small tag pool so sets fill and evict; some fully random.
    function automatic t_in_word random_word();
        logic [31:0] addr, stamp;
        if ($urandom_range(99) < 10) addr = $urandom();
        else addr = {22'($urandom_range(23) * 32'h0001_2345 + 32'h40_0000),
                     hot_sets[$urandom_range(3)]};
        if ($urandom_range(99) < 10) addr[31:10] = 22'($urandom_range(23));
        // stamps mostly climb, with ties and the odd random jump for wrap cases
        stamp_clock = stamp_clock + $urandom_range(3);
        stamp = ($urandom_range(99) < 8) ? $urandom() : stamp_clock;
        return make_word(1'($urandom_range(1)), addr, 1'($urandom_range(1)),
                         1'($urandom_range(1)), stamp);
    endfunction

    task automatic test_directed();
        set_config(5'(MODE_LRU), 5'd2, 5'd1);
        send_word(make_word(CMD_LOOKUP,  32'h0000_0000, 1'b0, 1'b0, 32'h0));        // cold miss
        send_word(make_word(CMD_INSTALL, 32'h0000_0000, 1'b0, 1'b0, 32'h0));
        send_word(make_word(CMD_LOOKUP,  32'h0000_0000, 1'b0, 1'b0, 32'h5));        // read hit
        send_word(make_word(CMD_LOOKUP,  32'h0000_0000, 1'b1, 1'b0, 32'h6));        // write hit
        send_word(make_word(CMD_LOOKUP,  32'h0000_0000, 1'b0, 1'b1, 32'h7));        // other core
        send_word(make_word(CMD_LOOKUP,  32'h0000_0000, 1'b1, 1'b1, 32'h7));
        send_word(make_word(CMD_INSTALL, 32'hFFFF_FC00, 1'b1, 1'b1, 32'hFFFF_FFFF));
        // set full: LRU evicts the dirty line of core 0
        send_word(make_word(CMD_INSTALL, 32'h0000_0400, 1'b0, 1'b1, 32'h8));
        // a duplicate install does no hit check and evicts the oldest way, here the first copy
        send_word(make_word(CMD_INSTALL, 32'h0000_0400, 1'b1, 1'b0, 32'h8));
        send_word(make_word(CMD_LOOKUP,  32'h0000_0400, 1'b0, 1'b0, 32'h9));
        send_word(make_word(CMD_INSTALL, 32'hFFFF_FFFF, 1'b1, 1'b1, 32'h0));
        send_word(make_word(CMD_INSTALL, 32'h0000_03FF, 1'b0, 1'b0, 32'h0));
        // equal stamps: lowest way is the victim
        send_word(make_word(CMD_INSTALL, 32'h1234_57FF, 1'b0, 1'b1, 32'h1));
        send_word(make_word(CMD_LOOKUP,  32'hFFFF_FFFF, 1'b1, 1'b1, 32'hFFFF_FFFF));
        send_word(make_word(CMD_LOOKUP,  32'hFFFF_FFFF, 1'b0, 1'b1, 32'h0));
        set_config(5'(MODE_RANDOM), 5'd2, 5'd1);
        send_word(make_word(CMD_INSTALL, 32'h0000_0800, 1'b1, 1'b0, 32'h20));
        send_word(make_word(CMD_INSTALL, 32'h0000_0C00, 1'b0, 1'b1, 32'h21));
        set_config(5'(MODE_PART), 5'd2, 5'd1);
        send_word(make_word(CMD_INSTALL, 32'h0000_1000, 1'b0, 1'b0, 32'h30));
        send_word(make_word(CMD_INSTALL, 32'h0000_1400, 1'b1, 1'b1, 32'h31));
        // core 1 partition empty when the split covers all active ways
        set_config(5'(MODE_PART), 5'd0, 5'd15);
        send_word(make_word(CMD_INSTALL, 32'h0000_1800, 1'b0, 1'b1, 32'h40));
        set_config(5'b11111, 5'd2, 5'd0);
        send_word(make_word(CMD_INSTALL, 32'h0000_1C00, 1'b1, 1'b0, 32'h50));
        send_word(make_word(CMD_LOOKUP,  32'h0000_1C00, 1'b1, 1'b0, 32'h51));
    endtask

    task automatic test_random_phase(int phase, int items, bit drain_midway);
        case (phase % 4)
            0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
            1: begin send_idle_pct = 70; recv_stall_pct = 0;  end
            2: begin send_idle_pct = 0;  recv_stall_pct = 70; end
            default: begin send_idle_pct = 32; recv_stall_pct = 32; end
        endcase
        for (int n = 0; n < items; n++) begin
            // hold off the sender until the block has handed back everything
            if (drain_midway && n == items / 2)
                while (expected_words.size() != 0) @(negedge i_clk);
            send_word(random_word());
        end
    endtask

    task automatic test_replacement_sweep();
        logic [4:0] cfgs[12][3] = '{
            '{5'd0, 5'd16, 5'd8},  '{5'd1, 5'd16, 5'd8},  '{5'd2, 5'd16, 5'd8},
            '{5'd2, 5'd4,  5'd1},  '{5'd2, 5'd4,  5'd15}, '{5'd3, 5'd3,  5'd2},
            '{5'd1, 5'd1,  5'd0},  '{5'd0, 5'd0,  5'd5},  '{5'd2, 5'd31, 5'd0},
            '{5'd1, 5'd17, 5'd15}, '{5'd0, 5'd5,  5'd3},  '{5'd2, 5'd7,  5'd6}};
        for (int c = 0; c < 12; c++) begin
            set_config(cfgs[c][0], cfgs[c][1], cfgs[c][2]);
            test_random_phase(c, 86, c == 5);
        end
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $display("%0t: %s mismatch: expected %h, actual %h", $time, name, exp_v, act_v);
            error_count++;
        end
    endtask

    // Receiver: pick ready at each falling edge
    always @(negedge i_clk)
        if (i_rst_n) i_ready = ($urandom_range(99) >= recv_stall_pct);

    // Compare each handed-off word with the oldest expectation
    always @(posedge i_clk) begin
        t_out_word exp_w;
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_words.size() == 0) begin
                $display("%0t: unexpected word, actual %h", $time, o_data);
                error_count++;
            end else begin
                exp_w = expected_words.pop_front();
                check_field("hit",             32'(exp_w.hit),           32'(o_data.hit));
                check_field("victim_way",      32'(exp_w.victim_way),    32'(o_data.victim_way));
                check_field("evicted_valid",   32'(exp_w.evicted_valid),
                            32'(o_data.evicted_valid));
                check_field("evicted_address", exp_w.evicted_address, o_data.evicted_address);
                check_field("evicted_dirty",   32'(exp_w.evicted_dirty),
                            32'(o_data.evicted_dirty));
                check_field("evicted_core",    32'(exp_w.evicted_core),  32'(o_data.evicted_core));
                check_field("read_accesses",   exp_w.read_accesses,   o_data.read_accesses);
                check_field("write_accesses",  exp_w.write_accesses,  o_data.write_accesses);
                check_field("read_misses",     exp_w.read_misses,     o_data.read_misses);
                check_field("write_misses",    exp_w.write_misses,    o_data.write_misses);
                check_field("dirty_evictions", exp_w.dirty_evictions, o_data.dirty_evictions);
            end
        end
    end

    initial begin
        i_rst_n     = 1'b0;
        i_valid     = 1'b0;
        i_ready     = 1'b0;
        i_data      = '0;
        i_cfg_we    = 1'b0;
        i_cfg_index = REG_MODE;
        i_cfg_data  = '0;
        for (int k = 0; k < LINES; k++) begin
            shadow_valid[k] = 1'b0;
            shadow_dirty[k] = 1'b0;
            shadow_owner[k] = 1'b0;
        end
        shadow_lfsr  = LFSR_SEED;
        cnt_rd = 0; cnt_wr = 0; cnt_rd_miss = 0; cnt_wr_miss = 0; cnt_dirty_ev = 0;
        cfg_mode = MODE_LRU;
        cfg_ways = 5'd16;
        cfg_core0 = 4'd8;
        hot_sets = '{10'd0, 10'd1023, 10'($urandom_range(1, 511)), 10'($urandom_range(512, 1022))};
        repeat (7) @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_replacement_sweep();

        wait_drained();
        repeat (40) @(negedge i_clk);
        if (error_count == 0 && expected_words.size() == 0)
            $display("set_assoc_cache_tag_store verification clean");
        else
            $display("set_assoc_cache_tag_store verification failed");
        $finish;
    end

    // Watchdog: clearing pass plus every word at worst-case stalls, several times over
    initial begin
        #20ms;
        $display("set_assoc_cache_tag_store verification failed");
        $finish;
    end

endmodule
